FILE: hdl/binary_blob_centroid_defines.svh
// Assertion macros shared by the blob centroid RTL.
`ifndef BINARY_BLOB_CENTROID_DEFINES_SVH
`define BINARY_BLOB_CENTROID_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BBC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

    localparam int SIZE_W  = 11;
    localparam int LEVEL_W = 8;
    localparam int SUM_W   = 30;
    localparam int CNT_W   = 21;
    localparam int CENT_W  = 10;

    typedef struct packed {
        logic [SUM_W-1:0] col_sum;
        logic [SUM_W-1:0] row_sum;
        logic [CNT_W-1:0] count;
        logic             frame_end;
    } t_acc_out;

endpackage

`default_nettype wire

FILE: hdl/bbc_accum.sv
`default_nettype none

module bbc_accum #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic                       i_clear,
    input  wire logic [bbc_pkg::LEVEL_W-1:0] i_level,
    input  wire logic [bbc_pkg::LEVEL_W-1:0] i_threshold,
    input  wire logic [bbc_pkg::SIZE_W-1:0]  i_width,
    input  wire logic [bbc_pkg::SIZE_W-1:0]  i_height,
    output bbc_pkg::t_acc_out                o_acc
);
    import bbc_pkg::*;

    localparam int PWC = $clog2(MAX_COLS);
    localparam int PWR = $clog2(MAX_ROWS);
    localparam int CWC = $clog2(MAX_COLS + 1);
    localparam int CWR = $clog2(MAX_ROWS + 1);
    localparam int EWC = (CWC > SIZE_W) ? CWC : SIZE_W;
    localparam int EWR = (CWR > SIZE_W) ? CWR : SIZE_W;

    logic [PWC-1:0]   r_col, n_col;
    logic [PWR-1:0]   r_row, n_row;
    logic [SUM_W-1:0] r_col_sum, n_col_sum;
    logic [SUM_W-1:0] r_row_sum, n_row_sum;
    logic [CNT_W-1:0] r_count, n_count;

    logic [EWC-1:0] width_ext, eff_w, col_inc;
    logic [EWR-1:0] height_ext, eff_h, row_inc;
    logic           row_end, frame_end, hit;

    always_comb begin
        width_ext  = EWC'(i_width);
        height_ext = EWR'(i_height);
        if (width_ext == '0) begin
            eff_w = EWC'(1);
        end else if (width_ext > EWC'(MAX_COLS)) begin
            eff_w = EWC'(MAX_COLS);
        end else begin
            eff_w = width_ext;
        end
        if (height_ext == '0) begin
            eff_h = EWR'(1);
        end else if (height_ext > EWR'(MAX_ROWS)) begin
            eff_h = EWR'(MAX_ROWS);
        end else begin
            eff_h = height_ext;
        end
        col_inc   = EWC'(r_col) + EWC'(1);
        row_inc   = EWR'(r_row) + EWR'(1);
        row_end   = col_inc >= eff_w;
        frame_end = row_end && (row_inc >= eff_h);
        hit       = i_level > i_threshold;
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_col_sum = r_col_sum;
        n_row_sum = r_row_sum;
        n_count   = r_count;
        if (i_clear) begin
            n_col_sum = '0;
            n_row_sum = '0;
            n_count   = '0;
        end else if (i_step) begin
            if (hit) begin
                n_col_sum = r_col_sum + SUM_W'(r_col);
                n_row_sum = r_row_sum + SUM_W'(r_row);
                n_count   = r_count + CNT_W'(1);
            end
            if (!row_end) begin
                n_col = col_inc[PWC-1:0];
            end else begin
                n_col = '0;
                n_row = frame_end ? '0 : row_inc[PWR-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_count   <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_col_sum <= n_col_sum;
            r_row_sum <= n_row_sum;
            r_count   <= n_count;
        end
    end

    assign o_acc.col_sum   = r_col_sum;
    assign o_acc.row_sum   = r_row_sum;
    assign o_acc.count     = r_count;
    assign o_acc.frame_end = frame_end;

endmodule

`default_nettype wire

FILE: hdl/bbc_div.sv
`default_nettype none

module bbc_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [bbc_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [bbc_pkg::CNT_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [bbc_pkg::SUM_W-1:0]     o_quotient
);
    import bbc_pkg::*;

    localparam int ITER_W = $clog2(SUM_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_dvs, n_dvs;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W:0]    shifted, diff;
    logic              fits;

    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        fits    = shifted >= {1'b0, r_dvs};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = ITER_W'(SUM_W - 1);
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], fits};
            n_cnt = r_cnt - ITER_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `include "binary_blob_centroid_defines.svh"

    `BBC_ASSERT_SAME(a_div_start_idle, i_start, !r_busy, "divider restarted while busy")
    `BBC_ASSERT_NEXT(a_div_last_done, r_busy && r_cnt == '0 && !i_start, r_done, "no done after last step")
    `BBC_ASSERT_SAME(a_div_done_idle, r_done, !r_busy, "done raised while busy")

endmodule

`default_nettype wire

FILE: hdl/binary_blob_centroid.sv
// Binary blob centroid.
// Input channel (i_in_valid / o_in_ready) takes one 8-bit pixel per item in
// raster order; column and row are tracked inside from frame_width and
// frame_height. Pixels strictly above level_threshold are foreground.
// Output channel (o_out_valid / i_out_ready) gives one item per frame: mean
// column, mean row, foreground count and an empty-frame flag.
// The last pixel of a frame starts two 30-step divisions on one shared
// restoring divider, one quotient bit per cycle; o_in_ready is low until
// the result is loaded. An empty frame skips the divider and its result is
// loaded straight from the S_START state.
// The result sits in an output register; pixels keep flowing while it waits,
// except that the last pixel of the next frame is held off until it is taken.
// Registers sit on the APB port at 0x0 (width), 0x4 (height), 0x8 (threshold).
// Synchronous active-low reset restores 640x480, threshold 1, and clears the
// position, sums and count.
`default_nettype none

module binary_blob_centroid #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [3:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [bbc_pkg::LEVEL_W-1:0] i_pixel_level,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [bbc_pkg::CENT_W-1:0]       o_centroid_col,
    output logic [bbc_pkg::CENT_W-1:0]       o_centroid_row,
    output logic [bbc_pkg::CNT_W-1:0]        o_foreground_count,
    output logic                             o_empty_frame
);
    import bbc_pkg::*;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_COL   = 4'b0100,
        S_ROW   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_frame_width, r_frame_height;
    logic [LEVEL_W-1:0] r_threshold;
    logic [CENT_W-1:0]  r_col_q, n_col_q;
    logic               r_out_valid, n_out_valid;
    logic [CENT_W-1:0]  r_out_col, n_out_col;
    logic [CENT_W-1:0]  r_out_row, n_out_row;
    logic [CNT_W-1:0]   r_out_cnt, n_out_cnt;
    logic               r_out_empty, n_out_empty;

    t_acc_out           acc;
    logic               in_accept, apb_write, load_out, clear_acc;
    logic               div_start, div_done;
    logic [SUM_W-1:0]   div_dividend, div_quotient;
    logic [1:0]         reg_idx;

    assign reg_idx   = paddr[3:2];
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= SIZE_W'(640);
            r_frame_height <= SIZE_W'(480);
            r_threshold    <= LEVEL_W'(1);
        end else if (apb_write) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[SIZE_W-1:0];
                REG_THRESHOLD:    r_threshold    <= pwdata[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            REG_THRESHOLD:    prdata = 32'(r_threshold);
            default:          prdata = '0;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE) && !(r_out_valid && acc.frame_end);
    assign in_accept  = i_in_valid && o_in_ready;

    bbc_accum #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_accept),
        .i_clear     (clear_acc),
        .i_level     (i_pixel_level),
        .i_threshold (r_threshold),
        .i_width     (r_frame_width),
        .i_height    (r_frame_height),
        .o_acc       (acc)
    );

    bbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (acc.count),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        n_state      = r_state;
        n_col_q      = r_col_q;
        div_start    = 1'b0;
        div_dividend = acc.col_sum;
        load_out     = 1'b0;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_out_cnt    = r_out_cnt;
        n_out_empty  = r_out_empty;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (in_accept && acc.frame_end) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (acc.count == '0) begin
                    load_out    = 1'b1;
                    n_out_col   = '0;
                    n_out_row   = '0;
                    n_out_cnt   = '0;
                    n_out_empty = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_COL;
                end
            end
            S_COL: begin
                if (div_done) begin
                    n_col_q      = div_quotient[CENT_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = acc.row_sum;
                    n_state      = S_ROW;
                end
            end
            S_ROW: begin
                if (div_done) begin
                    load_out    = 1'b1;
                    n_out_col   = r_col_q;
                    n_out_row   = div_quotient[CENT_W-1:0];
                    n_out_cnt   = acc.count;
                    n_out_empty = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    assign clear_acc = load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_col_q     <= n_col_q;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
        r_out_cnt   <= n_out_cnt;
        r_out_empty <= n_out_empty;
    end

    assign o_out_valid        = r_out_valid;
    assign o_centroid_col     = r_out_col;
    assign o_centroid_row     = r_out_row;
    assign o_foreground_count = r_out_cnt;
    assign o_empty_frame      = r_out_empty;

    `include "binary_blob_centroid_defines.svh"

    `BBC_ASSERT_SAME(a_out_no_overwrite, load_out, !r_out_valid, "result loaded over a pending item")
    `BBC_ASSERT_NEXT(a_frame_end_seq, in_accept && acc.frame_end, r_state == S_START, "frame end not sequenced")
    `BBC_ASSERT_SAME(a_empty_zero, r_out_valid && r_out_empty, r_out_col == '0 && r_out_row == '0 && r_out_cnt == '0, "empty frame with nonzero fields")

endmodule

`default_nettype wire
